>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; the scheduler top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge outside reset.
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PTD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PTD_ASSERT(lbl, prop, msg)
`define PTD_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/ptd_pkg.sv
package ptd_pkg;

  // Default configuration.
  localparam int NumPrioritiesDef = 32;
  localparam int TimeoutWidthDef  = 32;

  // Fixed field widths of the words.
  localparam int PrioW   = 6;
  localparam int TicksW  = 32;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DELAY = 2'd1,
    OP_TICK  = 2'd2,
    OP_SCHED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PRIO   = 2'd1,
    ST_IDLE_DELAY = 2'd2,
    ST_ZERO_DELAY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PrioW-1:0]  priority_req;
    logic [TicksW-1:0] delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic [PrioW-1:0] next_priority;
    logic             switch_request;
    logic [1:0]       status;
  } out_word_t;

endpackage

>>> rtl/ptd_timeout_ram.sv
module ptd_timeout_ram #(
  parameter int Depth = 32,
  parameter int Width = 32,
  parameter int AddrW = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/ptd_prio_enc.sv
module ptd_prio_enc #(
  parameter int NumPriorities = 32
) (
  input  logic [NumPriorities-1:0]  ready_i,
  output logic [ptd_pkg::PrioW-1:0] prio_o
);
  import ptd_pkg::*;

  // Highest set bit wins; bit i stands for priority i+1, none set gives idle.
  always_comb begin
    prio_o = '0;
    for (int i = 0; i < NumPriorities; i++) begin
      if (ready_i[i]) begin
        prio_o = PrioW'(i + 1);
      end
    end
  end

endmodule

>>> rtl/ptd_out_reg.sv
module ptd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ptd_pkg::out_word_t word_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptd_pkg::out_word_t out_word_o
);
  import ptd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  // The slot takes a new word when empty or when its word leaves this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i && free_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> rtl/priority_scheduler_tick_delay.sv
// Channel | Direction | Handshake              | Word
// input   | in        | in_valid_i, in_ready_o | in_word_i (opcode, priority_req, delay_ticks)
// output  | out       | out_valid_o, out_ready_i | out_word_o (next_priority, switch_request, status)
//
// Start, delay and schedule finish in the cycle they are accepted, and their word
// is then registered in the output register. A tick walks the timeout memory:
// its single read port reads one entry per cycle, then the result waits for the output register.
// Reset clears all masks and the current thread; the timeout memory is not cleared.
// A new word is taken only when the output register can accept the result.
`include "assert_macros.svh"

module priority_scheduler_tick_delay #(
  parameter int NumPriorities = ptd_pkg::NumPrioritiesDef,
  parameter int TimeoutWidth  = ptd_pkg::TimeoutWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptd_pkg::out_word_t out_word_o
);
  import ptd_pkg::*;

  localparam int IdxW  = (NumPriorities > 1) ? $clog2(NumPriorities) : 1;
  localparam int SIdxW = $clog2(NumPriorities + 1);
  localparam logic [PrioW-1:0] MaxPrio = PrioW'(NumPriorities);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(NumPriorities - 1);

  state_e state_q, state_d;
  logic [NumPriorities-1:0] ready_q, ready_d;
  logic [NumPriorities-1:0] delayed_q, delayed_d;
  logic [NumPriorities:0]   started_q, started_d;
  logic [PrioW-1:0]         current_q, current_d;
  logic                     cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]          wb_idx_q, wb_idx_d;

  logic                    accept, out_free, load_out, do_sched, sw;
  op_e                     op;
  status_e                 status;
  logic [PrioW-1:0]        hr, prio_m1, cur_m1;
  logic [TimeoutWidth-1:0] ticks, rd_data, tick_dec;
  logic                    wr_en, rd_en;
  logic [IdxW-1:0]         wr_addr, rd_addr;
  logic [TimeoutWidth-1:0] wr_data;
  out_word_t               res_word;

  assign op       = op_e'(in_word_i.opcode);
  assign accept   = in_valid_i && in_ready_o;
  assign ticks    = in_word_i.delay_ticks[TimeoutWidth-1:0];
  assign prio_m1  = in_word_i.priority_req - PrioW'(1);
  assign cur_m1   = current_q - PrioW'(1);
  assign tick_dec = rd_data - TimeoutWidth'(1);

  assign in_ready_o = (state_q == S_IDLE) && out_free;

  ptd_timeout_ram #(
    .Depth (NumPriorities),
    .Width (TimeoutWidth),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ptd_prio_enc #(
    .NumPriorities (NumPriorities)
  ) u_enc (
    .ready_i (ready_d),
    .prio_o  (hr)
  );

  ptd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_out),
    .word_i      (res_word),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op == OP_TICK) begin
          state_d = S_TICK;
        end
      end
      S_TICK: begin
        if (wb_idx_q == LastIdx) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Mask updates, memory accesses and status.
  always_comb begin
    ready_d   = ready_q;
    delayed_d = delayed_q;
    started_d = started_q;
    wb_idx_d  = wb_idx_q;
    status    = ST_OK;
    do_sched  = 1'b0;
    load_out  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = wb_idx_q;
    wr_data   = tick_dec;
    rd_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_START: begin
              load_out = 1'b1;
              if (in_word_i.priority_req > MaxPrio ||
                  started_q[in_word_i.priority_req[SIdxW-1:0]]) begin
                status = ST_BAD_PRIO;
              end else begin
                started_d[in_word_i.priority_req[SIdxW-1:0]] = 1'b1;
                if (in_word_i.priority_req != '0) begin
                  ready_d[prio_m1[IdxW-1:0]] = 1'b1;
                end
              end
            end
            OP_DELAY: begin
              load_out = 1'b1;
              if (!cur_valid_q || current_q == '0) begin
                status = ST_IDLE_DELAY;
              end else if (ticks == '0) begin
                status = ST_ZERO_DELAY;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cur_m1[IdxW-1:0];
                wr_data = ticks;
                ready_d[cur_m1[IdxW-1:0]]   = 1'b0;
                delayed_d[cur_m1[IdxW-1:0]] = 1'b1;
                do_sched = 1'b1;
              end
            end
            OP_TICK: begin
              // Prime the walk with the first entry.
              rd_en    = 1'b1;
              rd_addr  = '0;
              wb_idx_d = '0;
            end
            OP_SCHED: begin
              load_out = 1'b1;
              do_sched = 1'b1;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      S_TICK: begin
        // Write back the entry read last cycle if its thread is delayed, and fetch the next one if any.
        if (delayed_q[wb_idx_q]) begin
          wr_en = 1'b1;
          if (tick_dec == '0) begin
            ready_d[wb_idx_q]   = 1'b1;
            delayed_d[wb_idx_q] = 1'b0;
          end
        end
        if (wb_idx_q != LastIdx) begin
          rd_en    = 1'b1;
          rd_addr  = wb_idx_q + IdxW'(1);
          wb_idx_d = wb_idx_q + IdxW'(1);
        end
      end
      S_DONE: begin
        load_out = 1'b1;
      end
      default: ;
    endcase
  end

  // Scheduling decision and result word.
  always_comb begin
    current_d   = current_q;
    cur_valid_d = cur_valid_q;
    sw          = 1'b0;
    if (do_sched && (!cur_valid_q || hr != current_q)) begin
      sw          = 1'b1;
      current_d   = hr;
      cur_valid_d = 1'b1;
    end
    res_word.next_priority  = hr;
    res_word.switch_request = sw;
    res_word.status         = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= '0;
      delayed_q   <= '0;
      started_q   <= '0;
      current_q   <= '0;
      cur_valid_q <= 1'b0;
      wb_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      delayed_q   <= delayed_d;
      started_q   <= started_d;
      current_q   <= current_d;
      cur_valid_q <= cur_valid_d;
      wb_idx_q    <= wb_idx_d;
    end
  end

  // A thread is never both ready and delayed.
  `PTD_NEVER(a_masks_disjoint, (ready_q & delayed_q) != '0, "ready and delayed overlap")
  // An accepted tick starts the memory walk.
  `PTD_ASSERT(a_tick_walk, accept && op == OP_TICK |=> state_q == S_TICK, "tick walk missing")
  // The walk only writes back entries of delayed threads.
  `PTD_ASSERT(a_tick_wr, wr_en && state_q == S_TICK |-> delayed_q[wb_idx_q], "stray timeout write")
  // The current thread stays within the configured range.
  `PTD_ASSERT(a_cur_range, current_q <= MaxPrio, "current priority out of range")

endmodule
